@@ hw/rtl/sci_pkg.sv @@
`default_nettype none

package sci_pkg;

   localparam int COORD_W  = 16;
   localparam int RADIUS_W = COORD_W - 1;
   localparam int T_FRAC   = 16;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int RR_W     = 2 * RADIUS_W;
   localparam int A_W      = 34;
   localparam int H_W      = 35;
   localparam int SPLIT    = 18;
   localparam int HI_W     = H_W - SPLIT;
   localparam int PP_W     = HI_W + SPLIT + 1;
   localparam int HH_W     = 2 * HI_W;
   localparam int LL_W     = 2 * SPLIT;
   localparam int DISC_W   = 70;
   localparam int RAD_W    = 68;
   localparam int SQ_W     = RAD_W / 2 + T_FRAC;
   localparam int REM_W    = SQ_W + 2;
   localparam int NUM_W    = 53;
   localparam int MAG_W    = NUM_W - 1;
   localparam int T_W      = NUM_W;
   localparam int ENTRY_W  = 32;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic [RADIUS_W-1:0]       circle_radius;
   } sci_req_type;

   typedef struct packed {
      logic                      hit;
      logic                      roots_valid;
      logic signed [ENTRY_W-1:0] entry_t;
   } sci_rsp_type;

   typedef struct packed {
      logic [A_W-1:0]        a;
      logic signed [H_W-1:0] h;
      logic                  ok;
   } sci_sq_side_type;

   typedef struct packed {
      logic ok;
      logic neg1;
      logic neg2;
   } sci_dv_side_type;

endpackage

`default_nettype wire

@@ hw/rtl/sci_isqrt.sv @@
`default_nettype none

module sci_isqrt
   import sci_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [RAD_W-1:0] in_rad,
   input  wire sci_sq_side_type  in_side,
   output logic                  out_valid,
   output logic [SQ_W-1:0]       out_root,
   output sci_sq_side_type       out_side
);

   logic             valid_ff [SQ_W];
   logic [RAD_W-1:0] rad_ff   [SQ_W];
   logic [REM_W-1:0] rem_ff   [SQ_W];
   logic [SQ_W-1:0]  root_ff  [SQ_W];
   sci_sq_side_type  side_ff  [SQ_W];

   for (genvar g = 0; g < SQ_W; g++) begin : g_stage
      logic             valid_src;
      logic [RAD_W-1:0] rad_src;
      logic [REM_W-1:0] rem_src;
      logic [SQ_W-1:0]  root_src;
      sci_sq_side_type  side_src;
      logic [REM_W+1:0] shifted;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] diff;
      logic             ge;
      logic [RAD_W-1:0] rad_in;
      logic [REM_W-1:0] rem_in;
      logic [SQ_W-1:0]  root_in;

      if (g == 0) begin : g_first
         assign valid_src = in_valid;
         assign rad_src   = in_rad;
         assign rem_src   = '0;
         assign root_src  = '0;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[g-1];
         assign rad_src   = rad_ff[g-1];
         assign rem_src   = rem_ff[g-1];
         assign root_src  = root_ff[g-1];
         assign side_src  = side_ff[g-1];
      end

      always_comb begin
         shifted = {rem_src, rad_src[RAD_W-1 -: 2]};
         trial   = {2'b00, root_src, 2'b01};
         ge      = (shifted >= trial);
         diff    = shifted - trial;
         rem_in  = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
         root_in = {root_src[SQ_W-2:0], ge};
         rad_in  = {rad_src[RAD_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= valid_src;
         end
         if (en) begin
            rad_ff[g]  <= rad_in;
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
            side_ff[g] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[SQ_W-1];
   assign out_root  = root_ff[SQ_W-1];
   assign out_side  = side_ff[SQ_W-1];

endmodule

`default_nettype wire

@@ hw/rtl/sci_fdiv.sv @@
`default_nettype none

module sci_fdiv
   import sci_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [MAG_W-1:0] in_num1,
   input  wire logic [MAG_W-1:0] in_num2,
   input  wire logic [A_W-1:0]   in_den,
   input  wire sci_dv_side_type  in_side,
   output logic                  out_valid,
   output logic [MAG_W-1:0]      out_q1,
   output logic [MAG_W-1:0]      out_q2,
   output sci_dv_side_type       out_side
);

   logic             valid_ff [MAG_W];
   logic [A_W-1:0]   den_ff   [MAG_W];
   sci_dv_side_type  side_ff  [MAG_W];
   logic [MAG_W-1:0] num_ff   [MAG_W][2];
   logic [A_W-1:0]   rem_ff   [MAG_W][2];

   for (genvar g = 0; g < MAG_W; g++) begin : g_stage
      logic            valid_src;
      logic [A_W-1:0]  den_src;
      sci_dv_side_type side_src;

      if (g == 0) begin : g_first
         assign valid_src = in_valid;
         assign den_src   = in_den;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[g-1];
         assign den_src   = den_ff[g-1];
         assign side_src  = side_ff[g-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= valid_src;
         end
         if (en) begin
            den_ff[g]  <= den_src;
            side_ff[g] <= side_src;
         end
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [MAG_W-1:0] num_src;
         logic [A_W-1:0]   rem_src;
         logic [A_W:0]     shifted;
         logic [A_W:0]     diff;
         logic             ge;
         logic [MAG_W-1:0] num_in;
         logic [A_W-1:0]   rem_in;

         if (g == 0) begin : g_first
            assign num_src = (l == 0) ? in_num1 : in_num2;
            assign rem_src = '0;
         end else begin : g_next
            assign num_src = num_ff[g-1][l];
            assign rem_src = rem_ff[g-1][l];
         end

         always_comb begin
            shifted = {rem_src, num_src[MAG_W-1]};
            ge      = (shifted >= {1'b0, den_src});
            diff    = shifted - {1'b0, den_src};
            rem_in  = ge ? diff[A_W-1:0] : shifted[A_W-1:0];
            num_in  = {num_src[MAG_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               num_ff[g][l] <= num_in;
               rem_ff[g][l] <= rem_in;
            end
         end
      end
   end

   assign out_valid = valid_ff[MAG_W-1];
   assign out_q1    = num_ff[MAG_W-1][0];
   assign out_q2    = num_ff[MAG_W-1][1];
   assign out_side  = side_ff[MAG_W-1];

endmodule

`default_nettype wire

@@ hw/rtl/segment_circle_intersection.sv @@
// Segment against circle intersection test, fully pipelined.
// The request channel (req_valid, req_stall, req_data) carries one segment,
// circle centre (signed Q8.8) and radius (unsigned Q7.8) per transaction.
// The response channel (rsp_valid, rsp_stall, rsp_data) returns hit,
// roots_valid and the smaller root entry_t in Q15.16, saturated, one
// response per request, in order. A zero-length segment or a negative
// discriminant gives all zeros. A new transaction is taken in every cycle
// unless the pipeline is stalled. The datapath is 113 register stages deep:
// input register, six stages of products and sums for the quadratic and its
// discriminant, a 50-stage one-bit-per-stage square root, two stages that
// form the numerators, a 52-stage one-bit-per-stage divider with two lanes,
// a sign stage and the output register.
// When the receiver stalls a valid response, the whole pipeline holds and
// req_stall is raised in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty afterwards.
`default_nettype none

module segment_circle_intersection
   import sci_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire sci_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output sci_rsp_type      rsp_data
);

   localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

   function automatic logic in_unit(input logic signed [T_W-1:0] t);
      in_unit = !t[T_W-1] && ($unsigned(t) <= T_ONE);
   endfunction

   function automatic logic [ENTRY_W-1:0] sat_entry(input logic signed [T_W-1:0] t);
      logic fits;
      fits = (t[T_W-1:ENTRY_W-1] == '0) || (t[T_W-1:ENTRY_W-1] == '1);
      if (fits) begin
         sat_entry = t[ENTRY_W-1:0];
      end else if (t[T_W-1]) begin
         sat_entry = {1'b1, {(ENTRY_W-1){1'b0}}};
      end else begin
         sat_entry = {1'b0, {(ENTRY_W-1){1'b1}}};
      end
   endfunction

   logic en;

   logic        s0_v_ff;
   sci_req_type s0_req_ff;

   logic                     s1_v_ff;
   logic signed [DIFF_W-1:0] s1_dx_ff, s1_dy_ff, s1_fx_ff, s1_fy_ff;
   logic [RADIUS_W-1:0]      s1_r_ff;
   logic signed [DIFF_W-1:0] s1_dx_in, s1_dy_in, s1_fx_in, s1_fy_in;

   logic                     s2_v_ff;
   logic signed [PROD_W-1:0] s2_dxx_ff, s2_dyy_ff, s2_fdx_ff, s2_fdy_ff, s2_fxx_ff, s2_fyy_ff;
   logic [RR_W-1:0]          s2_rr_ff;

   logic                  s3_v_ff;
   logic [A_W-1:0]        s3_a_ff;
   logic signed [H_W-1:0] s3_h_ff, s3_c_ff;
   logic [A_W-1:0]        s3_a_in;
   logic signed [H_W-1:0] s3_h_in, s3_c_in;

   logic                   s4_v_ff;
   logic [A_W-1:0]         s4_a_ff;
   logic signed [H_W-1:0]  s4_h_ff;
   logic signed [HH_W-1:0] s4_hh_hh_ff, s4_ac_hh_ff;
   logic signed [PP_W-1:0] s4_hh_hl_ff, s4_ac_hl_ff, s4_ac_lh_ff;
   logic [LL_W-1:0]        s4_hh_ll_ff, s4_ac_ll_ff;
   logic signed [HI_W-1:0] h_hi, a_hi, c_hi;
   logic signed [SPLIT:0]  h_lo, a_lo, c_lo;

   logic                     s5_v_ff;
   logic [A_W-1:0]           s5_a_ff;
   logic signed [H_W-1:0]    s5_h_ff;
   logic signed [DISC_W-1:0] s5_hh_ff, s5_ac_ff;
   logic signed [DISC_W-1:0] s5_hh_in, s5_ac_in;

   logic                     s6_v_ff;
   logic [RAD_W-1:0]         s6_rad_ff;
   sci_sq_side_type          s6_side_ff;
   logic signed [DISC_W-1:0] disc;
   logic                     s6_ok;

   logic            sq_valid;
   logic [SQ_W-1:0] sq_root;
   sci_sq_side_type sq_side;

   logic                    nm_v_ff, nm_ok_ff;
   logic [A_W-1:0]          nm_a_ff;
   logic signed [NUM_W-1:0] nm_n1_ff, nm_n2_ff;
   logic signed [NUM_W-1:0] hs, nm_n1_in, nm_n2_in;

   logic             pr_v_ff;
   logic [A_W-1:0]   pr_a_ff;
   logic [MAG_W-1:0] pr_m1_ff, pr_m2_ff;
   sci_dv_side_type  pr_side_ff;
   logic [NUM_W-1:0] sum1, sum2;
   sci_dv_side_type  pr_side_in;

   logic             dv_valid;
   logic [MAG_W-1:0] dv_q1, dv_q2;
   sci_dv_side_type  dv_side;

   logic                  tf_v_ff, tf_ok_ff;
   logic signed [T_W-1:0] tf_t1_ff, tf_t2_ff;

   logic        rsp_valid_ff;
   sci_rsp_type rsp_data_ff;
   sci_rsp_type rsp_data_in;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_comb begin
      s1_dx_in = DIFF_W'(s0_req_ff.end_x) - DIFF_W'(s0_req_ff.start_x);
      s1_dy_in = DIFF_W'(s0_req_ff.end_y) - DIFF_W'(s0_req_ff.start_y);
      s1_fx_in = DIFF_W'(s0_req_ff.start_x) - DIFF_W'(s0_req_ff.center_x);
      s1_fy_in = DIFF_W'(s0_req_ff.start_y) - DIFF_W'(s0_req_ff.center_y);
   end

   always_comb begin
      s3_a_in = s2_dxx_ff + s2_dyy_ff;
      s3_h_in = H_W'(s2_fdx_ff) + H_W'(s2_fdy_ff);
      s3_c_in = H_W'(s2_fxx_ff) + H_W'(s2_fyy_ff) - H_W'(s2_rr_ff);
   end

   always_comb begin
      h_hi = $signed(s3_h_ff[H_W-1:SPLIT]);
      h_lo = $signed({1'b0, s3_h_ff[SPLIT-1:0]});
      a_hi = $signed({{(H_W-A_W){1'b0}}, s3_a_ff[A_W-1:SPLIT]});
      a_lo = $signed({1'b0, s3_a_ff[SPLIT-1:0]});
      c_hi = $signed(s3_c_ff[H_W-1:SPLIT]);
      c_lo = $signed({1'b0, s3_c_ff[SPLIT-1:0]});
   end

   always_comb begin
      s5_hh_in = (DISC_W'(s4_hh_hh_ff) <<< (2 * SPLIT))
               + (DISC_W'(s4_hh_hl_ff) <<< (SPLIT + 1))
               + DISC_W'(s4_hh_ll_ff);
      s5_ac_in = (DISC_W'(s4_ac_hh_ff) <<< (2 * SPLIT))
               + ((DISC_W'(s4_ac_hl_ff) + DISC_W'(s4_ac_lh_ff)) <<< SPLIT)
               + DISC_W'(s4_ac_ll_ff);
   end

   always_comb begin
      disc  = s5_hh_ff - s5_ac_ff;
      s6_ok = (s5_a_ff != '0) && !disc[DISC_W-1];
   end

   always_comb begin
      hs       = -(NUM_W'(sq_side.h) <<< T_FRAC);
      nm_n1_in = hs - NUM_W'(sq_root);
      nm_n2_in = hs + NUM_W'(sq_root);
   end

   always_comb begin
      sum1            = ~nm_n1_ff + NUM_W'(nm_a_ff);
      sum2            = ~nm_n2_ff + NUM_W'(nm_a_ff);
      pr_side_in.ok   = nm_ok_ff;
      pr_side_in.neg1 = nm_n1_ff[NUM_W-1];
      pr_side_in.neg2 = nm_n2_ff[NUM_W-1];
   end

   always_comb begin
      rsp_data_in.roots_valid = tf_ok_ff;
      rsp_data_in.hit         = tf_ok_ff && (in_unit(tf_t1_ff) || in_unit(tf_t2_ff));
      rsp_data_in.entry_t     = tf_ok_ff ? sat_entry(tf_t1_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff      <= 1'b0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         s4_v_ff      <= 1'b0;
         s5_v_ff      <= 1'b0;
         s6_v_ff      <= 1'b0;
         nm_v_ff      <= 1'b0;
         pr_v_ff      <= 1'b0;
         tf_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff      <= req_valid;
         s1_v_ff      <= s0_v_ff;
         s2_v_ff      <= s1_v_ff;
         s3_v_ff      <= s2_v_ff;
         s4_v_ff      <= s3_v_ff;
         s5_v_ff      <= s4_v_ff;
         s6_v_ff      <= s5_v_ff;
         nm_v_ff      <= sq_valid;
         pr_v_ff      <= nm_v_ff;
         tf_v_ff      <= dv_valid;
         rsp_valid_ff <= tf_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_req_ff <= req_data;

         s1_dx_ff <= s1_dx_in;
         s1_dy_ff <= s1_dy_in;
         s1_fx_ff <= s1_fx_in;
         s1_fy_ff <= s1_fy_in;
         s1_r_ff  <= s0_req_ff.circle_radius;

         s2_dxx_ff <= s1_dx_ff * s1_dx_ff;
         s2_dyy_ff <= s1_dy_ff * s1_dy_ff;
         s2_fdx_ff <= s1_fx_ff * s1_dx_ff;
         s2_fdy_ff <= s1_fy_ff * s1_dy_ff;
         s2_fxx_ff <= s1_fx_ff * s1_fx_ff;
         s2_fyy_ff <= s1_fy_ff * s1_fy_ff;
         s2_rr_ff  <= s1_r_ff * s1_r_ff;

         s3_a_ff <= s3_a_in;
         s3_h_ff <= s3_h_in;
         s3_c_ff <= s3_c_in;

         s4_a_ff     <= s3_a_ff;
         s4_h_ff     <= s3_h_ff;
         s4_hh_hh_ff <= h_hi * h_hi;
         s4_hh_hl_ff <= h_hi * h_lo;
         s4_hh_ll_ff <= s3_h_ff[SPLIT-1:0] * s3_h_ff[SPLIT-1:0];
         s4_ac_hh_ff <= a_hi * c_hi;
         s4_ac_hl_ff <= a_hi * c_lo;
         s4_ac_lh_ff <= a_lo * c_hi;
         s4_ac_ll_ff <= s3_a_ff[SPLIT-1:0] * s3_c_ff[SPLIT-1:0];

         s5_a_ff  <= s4_a_ff;
         s5_h_ff  <= s4_h_ff;
         s5_hh_ff <= s5_hh_in;
         s5_ac_ff <= s5_ac_in;

         s6_rad_ff     <= s6_ok ? disc[RAD_W-1:0] : '0;
         s6_side_ff.a  <= s5_a_ff;
         s6_side_ff.h  <= s5_h_ff;
         s6_side_ff.ok <= s6_ok;

         nm_ok_ff <= sq_side.ok;
         nm_a_ff  <= sq_side.a;
         nm_n1_ff <= nm_n1_in;
         nm_n2_ff <= nm_n2_in;

         pr_a_ff    <= nm_a_ff;
         pr_side_ff <= pr_side_in;
         pr_m1_ff   <= pr_side_in.neg1 ? sum1[MAG_W-1:0] : nm_n1_ff[MAG_W-1:0];
         pr_m2_ff   <= pr_side_in.neg2 ? sum2[MAG_W-1:0] : nm_n2_ff[MAG_W-1:0];

         tf_ok_ff <= dv_side.ok;
         tf_t1_ff <= dv_side.neg1 ? -T_W'(dv_q1) : T_W'(dv_q1);
         tf_t2_ff <= dv_side.neg2 ? -T_W'(dv_q2) : T_W'(dv_q2);

         rsp_data_ff <= rsp_data_in;
      end
   end

   sci_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s6_v_ff),
      .in_rad    (s6_rad_ff),
      .in_side   (s6_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   sci_fdiv u_fdiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pr_v_ff),
      .in_num1   (pr_m1_ff),
      .in_num2   (pr_m2_ff),
      .in_den    (pr_a_ff),
      .in_side   (pr_side_ff),
      .out_valid (dv_valid),
      .out_q1    (dv_q1),
      .out_q2    (dv_q2),
      .out_side  (dv_side)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/sci_checker.sv @@
`default_nettype none

module sci_checker
   import sci_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire sci_rsp_type rsp_data
);

   // A stalled response stays presented with the same contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // The request side is held off exactly when a response is stalled.
   assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow response stall");

   // Without roots there is neither a hit nor an entry value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.roots_valid |-> !rsp_data.hit && (rsp_data.entry_t == '0))
      else $error("response without roots carries data");

   // No response is presented right after reset is released.
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid)
      else $error("response present right after reset");

endmodule

bind segment_circle_intersection sci_checker u_sci_checker (.*);

`default_nettype wire

@@ tb/sv/segment_circle_intersection_checker.sv @@
`default_nettype none

module segment_circle_intersection_checker
   import sci_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire sci_req_type req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire sci_rsp_type rsp_data,
   output int               failures,
   output int               pending,
   output int               results,
   output int               hits
);

   typedef logic signed [127:0] big_type;

   sci_rsp_type expected_rsps[$];

   function automatic big_type floor_quotient(big_type num, big_type den);
      big_type q;
      q = num / den;
      if (num < 0 && q * den != num) begin
         q = q - 1;
      end
      return q;
   endfunction

   function automatic logic on_segment(big_type t);
      return t >= 0 && t <= (big_type'(1) <<< T_FRAC);
   endfunction

   function automatic sci_rsp_type predict_intersection(sci_req_type q);
      big_type sx, sy, ex, ey, cx, cy, r;
      big_type dx, dy, fx, fy, a, h, c, disc, x, s, cand, hs, t1, t2;
      sci_rsp_type p;
      sx = q.start_x;
      sy = q.start_y;
      ex = q.end_x;
      ey = q.end_y;
      cx = q.center_x;
      cy = q.center_y;
      r = {113'b0, q.circle_radius};
      dx = ex - sx;
      dy = ey - sy;
      fx = sx - cx;
      fy = sy - cy;
      a = dx * dx + dy * dy;
      h = fx * dx + fy * dy;
      c = fx * fx + fy * fy - r * r;
      disc = h * h - a * c;
      p = '0;
      if (a == 0 || disc < 0) begin
         return p;
      end
      x = disc <<< (2 * T_FRAC);
      s = 0;
      for (int i = 63; i >= 0; i--) begin
         cand = s | (big_type'(1) <<< i);
         if (cand * cand <= x) begin
            s = cand;
         end
      end
      hs = -(h <<< T_FRAC);
      t1 = floor_quotient(hs - s, a);
      t2 = floor_quotient(hs + s, a);
      p.hit = on_segment(t1) || on_segment(t2);
      p.roots_valid = 1'b1;
      if (t1 > 128'sh7FFFFFFF) begin
         p.entry_t = 32'h7FFFFFFF;
      end else if (t1 < -128'sh80000000) begin
         p.entry_t = 32'h80000000;
      end else begin
         p.entry_t = t1[31:0];
      end
      return p;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at result %0d: %s got %0h expected %0h", results, what, got, want);
      failures++;
   endtask

   initial begin
      failures = 0;
      pending = 0;
      results = 0;
      hits = 0;
   end

   always @(posedge clock) begin
      sci_rsp_type e;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(predict_intersection(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected transaction", 0, 0);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_data.hit !== e.hit) begin
                  report_mismatch("hit", rsp_data.hit, e.hit);
               end
               if (rsp_data.roots_valid !== e.roots_valid) begin
                  report_mismatch("roots_valid", rsp_data.roots_valid, e.roots_valid);
               end
               if (rsp_data.entry_t !== e.entry_t) begin
                  report_mismatch("entry_t", rsp_data.entry_t, e.entry_t);
               end
               if (e.hit) begin
                  hits++;
               end
            end
            results++;
         end
         pending = expected_rsps.size();
      end
   end

endmodule

`default_nettype wire

@@ tb/sv/segment_circle_intersection_test.sv @@
`default_nettype none

module segment_circle_intersection_test;
   import sci_pkg::*;

   localparam int RANDOM_ITEMS = 1730;
   localparam int STALL_LIMIT  = 5000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   sci_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   sci_rsp_type rsp_data;
   int          failures;
   int          pending;
   int          results;
   int          hits;
   int          sent;
   int          quiet_cycles;

   segment_circle_intersection dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   segment_circle_intersection_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .failures(failures),
      .pending(pending),
      .results(results),
      .hits(hits)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic send_query(sci_req_type q, logic may_idle);
      if (may_idle && $urandom_range(99) < 20) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(4)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= q;
      do begin
         @(posedge clock);
      end while (req_stall);
      sent++;
   endtask

   function automatic sci_req_type make_query(int sx, int sy, int ex, int ey,
                                             int cx, int cy, int r);
      sci_req_type q;
      q.start_x = COORD_W'(sx);
      q.start_y = COORD_W'(sy);
      q.end_x = COORD_W'(ex);
      q.end_y = COORD_W'(ey);
      q.center_x = COORD_W'(cx);
      q.center_y = COORD_W'(cy);
      q.circle_radius = RADIUS_W'(r);
      return q;
   endfunction

   function automatic int near(int base, int span);
      return base + $signed($urandom_range(2 * span)) - span;
   endfunction

   initial begin
      int cx, cy;
      sci_req_type q;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Crossing, tangent, miss, zero-length, inside and extreme cases.
      send_query(make_query(-512, 0, 512, 0, 0, 0, 256), 1'b0);
      send_query(make_query(-512, 256, 512, 256, 0, 0, 256), 1'b0);
      send_query(make_query(-512, 1024, 512, 1024, 0, 0, 256), 1'b0);
      send_query(make_query(100, 100, 100, 100, 0, 0, 256), 1'b0);
      send_query(make_query(0, 0, 0, 0, 0, 0, 0), 1'b0);
      send_query(make_query(-10, 0, 10, 0, 0, 0, 2560), 1'b0);
      send_query(make_query(0, 0, 256, 0, 0, 0, 0), 1'b0);
      send_query(make_query(-1000, -1000, -900, -900, 0, 0, 256), 1'b0);
      send_query(make_query(-32768, -32768, 32767, 32767, 0, 0, 32767), 1'b0);
      send_query(make_query(32767, 32767, -32768, -32768, -32768, 32767, 32767), 1'b0);
      send_query(make_query(-32768, 0, -32767, 0, 32767, 0, 1), 1'b0);
      send_query(make_query(-32768, 0, -32767, 0, 32767, 0, 32767), 1'b0);
      send_query(make_query(32767, -32768, 32767, -32768, 0, 0, 32767), 1'b0);
      send_query(make_query(0, 0, 1, 0, 0, 0, 32767), 1'b0);
      send_query(make_query(-32768, -32768, -32768, 32767, 32767, 0, 0), 1'b0);
      send_query(make_query(0, -256, 0, 256, 256, 0, 256), 1'b0);
      send_query(make_query(512, 0, -512, 0, 0, 0, 256), 1'b0);
      send_query(make_query(0, 0, 512, 0, 0, 0, 256), 1'b0);
      send_query(make_query(-1, -1, 32767, 32767, 0, 0, 32767), 1'b0);
      send_query(make_query(-32768, 32767, 32767, -32768, 0, 0, 0), 1'b0);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(99) < 30) begin
            q.start_x = COORD_W'($urandom);
            q.start_y = COORD_W'($urandom);
            q.end_x = COORD_W'($urandom);
            q.end_y = COORD_W'($urandom);
            q.center_x = COORD_W'($urandom);
            q.center_y = COORD_W'($urandom);
            q.circle_radius = RADIUS_W'($urandom);
         end else begin
            cx = near(0, 20000);
            cy = near(0, 20000);
            q = make_query(near(cx, 3000), near(cy, 3000), near(cx, 3000),
                           near(cy, 3000), cx, cy, $urandom_range(4000));
         end
         send_query(q, !(i >= 600 && i < 1400));
      end
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      $display("Sent %0d segment queries and checked %0d responses, %0d of them hits.",
               sent, results, hits);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      for (int n = 0; ; n++) begin
         @(negedge clock);
         if (n >= 1500 && n < 1900) begin
            rsp_stall <= 1'b1;
         end else if (n >= 1900 && n < 2500) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= $urandom_range(99) < 20;
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timed out with %0d responses outstanding.", pending);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/sci_pkg.sv
hw/rtl/sci_isqrt.sv
hw/rtl/sci_fdiv.sv
hw/rtl/segment_circle_intersection.sv
hw/rtl/sci_checker.sv
tb/sv/segment_circle_intersection_checker.sv
tb/sv/segment_circle_intersection_test.sv
